/* design/rowf_pkg.sv */
// Package: shared types and constants of the rank-order window filter.
`default_nettype none
package rowf_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_MODE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PAD_VALUE    = 3'd4;

  // filter modes
  localparam logic [1:0] MODE_MEDIAN   = 2'd0;
  localparam logic [1:0] MODE_MINIMUM  = 2'd1;
  localparam logic [1:0] MODE_MAXIMUM  = 2'd2;
  localparam logic [1:0] MODE_MIDPOINT = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic accept;     // input transfer, start line store read
    logic load;       // shift window, write line store, step counters
    logic scan_step;  // one column of the min/max scan
    logic rank_step;  // one column of the median bit search
    logic out_load;   // move result into the output register
  } rowf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit;       // current position completes a window
    logic scan_last;  // scan is on the last window column
    logic rank_last;  // last column of the last bit pass
    logic median;     // mode needs the bit search
    logic out_free;   // output register can take a result
  } rowf_status_t;

endpackage
`default_nettype wire

/* design/rank_order_window_filter.sv */
// Top level of the rank-order window filter (median, minimum, maximum, midpoint).
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_tvalid/in_tready   | tdata pixel_value, tuser action
//  out_    | output    | out_tvalid/out_tready | tdata out_pixel, tlast end_of_row,
//          |           |                       | tuser end_of_frame
//  cfg_    | input     | cfg_we                | cfg_addr index, cfg_wdata value
//
//  A position that completes no window passes a store read and a window load.
//  One that completes a window then scans the K window columns for minimum, maximum
//  and midpoint, and for median also runs the bit search: the window is scanned one
//  column a cycle, and the median is found by an 8-pass bit search over the columns.
//  Reset: synchronous, active low; config takes its defaults, counters clear.
//  A result waiting in the output register does not stop the next input transfer.
`default_nettype none
module rank_order_window_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rowf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [rowf_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] pixel_value
  input  wire logic                            in_tuser,   // [0] action
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [7:0]                      out_tdata,  // [7:0] out_pixel
  output      logic                            out_tlast,  // end_of_row
  output      logic                            out_tuser   // [0] end_of_frame
);
  import rowf_pkg::*;

  rowf_cmd_t    cmd;
  rowf_status_t status;

  rowf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rowf_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_action  (in_tuser),
    .in_pixel   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pixel  (out_tdata),
    .out_eor    (out_tlast),
    .out_eof    (out_tuser),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
`default_nettype wire

/* design/rowf_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rowf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/rowf_ctrl.sv */
// Controller state machine of the rank-order window filter.
`default_nettype none
module rowf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  input  wire rowf_pkg::rowf_status_t status,
  output      rowf_pkg::rowf_cmd_t    cmd
);
  import rowf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MINMAX, ST_RANK, ST_HOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   ready_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid && ready_r) state_nxt = ST_LOAD;
      ST_LOAD:   state_nxt = status.emit ? ST_MINMAX : ST_IDLE;
      ST_MINMAX: if (status.scan_last) state_nxt = status.median ? ST_RANK : ST_HOLD;
      ST_RANK:   if (status.rank_last) state_nxt = ST_HOLD;
      ST_HOLD:   if (status.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ready_r <= (state_nxt == ST_IDLE);
    end
  end

  assign in_tready = ready_r;

  // commands
  always_comb begin
    cmd           = '0;
    cmd.accept    = in_tvalid && ready_r;
    cmd.load      = (state_r == ST_LOAD);
    cmd.scan_step = (state_r == ST_MINMAX);
    cmd.rank_step = (state_r == ST_RANK);
    cmd.out_load  = (state_r == ST_HOLD) && status.out_free;
  end

  a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == ST_LOAD) else $error("accept not followed by load");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == ST_IDLE) else $error("hold did not release");

endmodule
`default_nettype wire

/* design/rowf_datapath.sv */
// Datapath: config registers, counters, line store, window and rank search.
`default_nettype none
module rowf_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 7
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rowf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [rowf_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                            in_action,
  input  wire logic [rowf_pkg::PIX_W-1:0]      in_pixel,
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [rowf_pkg::PIX_W-1:0]      out_pixel,
  output      logic                            out_eor,
  output      logic                            out_eof,
  input  wire rowf_pkg::rowf_cmd_t             cmd,
  output      rowf_pkg::rowf_status_t          status
);
  import rowf_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EW  = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int KW  = $clog2(MAX_WINDOW + 1);
  localparam int KE  = (KW > 3) ? KW : 3;
  localparam int JW  = $clog2(MAX_WINDOW);
  localparam int NW  = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int LW  = (MAX_WINDOW - 1) * PIX_W;
  localparam logic [EW-1:0] MAXW_E = EW'(MAX_WIDTH);
  localparam logic [KE-1:0] MAXK_E = KE'(MAX_WINDOW);
  localparam logic [JW-1:0] JLAST  = JW'(MAX_WINDOW - 1);

  // configuration registers
  logic [10:0] frame_width_r;
  logic [15:0] frame_height_r;
  logic [2:0]  window_size_r;
  logic [1:0]  filter_mode_r;
  logic [7:0]  pad_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 11'd1024;
      frame_height_r <= 16'd1024;
      window_size_r  <= 3'd3;
      filter_mode_r  <= MODE_MEDIAN;
      pad_value_r    <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[10:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[15:0];
        REG_WINDOW_SIZE:  window_size_r  <= cfg_wdata[2:0];
        REG_FILTER_MODE:  filter_mode_r  <= cfg_wdata[1:0];
        REG_PAD_VALUE:    pad_value_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [EW-1:0] w_ext, w_eff;
  logic [16:0]   h_eff;
  logic [KE-1:0] k_ext, k_eff;
  logic [NW-1:0] rank_idx;
  logic [JW-1:0] jstart;

  always_comb begin
    w_ext = EW'(frame_width_r);
    if (w_ext == '0) w_eff = EW'(1);
    else if (w_ext > MAXW_E) w_eff = MAXW_E;
    else w_eff = w_ext;
    h_eff = (frame_height_r == 16'd0) ? 17'd1 : {1'b0, frame_height_r};
    k_ext = KE'(window_size_r);
    if (k_ext == '0) k_eff = KE'(1);
    else if (k_ext > MAXK_E) k_eff = MAXK_E;
    else k_eff = k_ext;
    rank_idx = NW'((NW'(k_eff) * NW'(k_eff)) >> 1);
    jstart   = JW'(MAXK_E - k_eff);
  end

  // counters and captured pixel
  logic [CW-1:0]    col_r;
  logic [15:0]      row_r;
  logic [PIX_W-1:0] px_r;
  logic [LW-1:0]    line_rd, line_wr;
  logic             last_col, last_row;

  assign last_col = (EW'(col_r) + EW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_r} + 17'd1) >= h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.load) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px_r <= in_action ? pad_value_r : in_pixel;
    end
  end

  // line store: one word per column, rows above packed low to high
  assign line_wr = {line_rd[LW-PIX_W-1:0], px_r};

  rowf_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (col_r),
    .wdata (line_wr),
    .re    (cmd.accept),
    .raddr (col_r),
    .rdata (line_rd)
  );

  // window emits when column and row both reach k-1
  assign status.emit = ((EW'(col_r) + EW'(1)) >= EW'(k_eff))
                    && (({1'b0, row_r} + 17'd1) >= 17'(k_eff));

  // window shift register, column index MAX_WINDOW-1 newest
  logic [PIX_W-1:0] win_r [MAX_WINDOW][MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < MAX_WINDOW - 1; j++) begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
          win_r[j][i] <= win_r[j+1][i];
        end
      end
      win_r[MAX_WINDOW-1][0] <= px_r;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        win_r[MAX_WINDOW-1][i] <= line_rd[(i-1)*PIX_W +: PIX_W];
      end
    end
  end

  // column-serial scan
  logic [JW-1:0]    j_r;
  logic [2:0]       b_r;
  logic [NW-1:0]    cnt_r;
  logic [PIX_W-1:0] lo_r, hi_r, p_r;
  logic [PIX_W-1:0] col_lo, col_hi, cand;
  logic [NW-1:0]    col_cnt, total;
  logic             eor_r, eof_r;

  always_comb begin
    col_lo  = lo_r;
    col_hi  = hi_r;
    col_cnt = '0;
    cand    = p_r | (PIX_W'(1) << b_r);
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (KE'(i) < k_eff) begin
        if (win_r[j_r][i] < col_lo) col_lo = win_r[j_r][i];
        if (win_r[j_r][i] > col_hi) col_hi = win_r[j_r][i];
        if (win_r[j_r][i] < cand) col_cnt = col_cnt + NW'(1);
      end
    end
    total = cnt_r + col_cnt;
  end

  assign status.scan_last = (j_r == JLAST);
  assign status.rank_last = (j_r == JLAST) && (b_r == 3'd0);
  assign status.median    = (filter_mode_r == MODE_MEDIAN);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      j_r   <= jstart;
      b_r   <= 3'd7;
      cnt_r <= '0;
      lo_r  <= 8'd255;
      hi_r  <= 8'd0;
      p_r   <= '0;
      eor_r <= last_col;
      eof_r <= last_col && last_row;
    end else if (cmd.scan_step) begin
      lo_r <= col_lo;
      hi_r <= col_hi;
      j_r  <= (j_r == JLAST) ? jstart : j_r + JW'(1);
    end else if (cmd.rank_step) begin
      if (j_r == JLAST) begin
        if (total <= rank_idx) p_r <= cand;
        cnt_r <= '0;
        j_r   <= jstart;
        b_r   <= b_r - 3'd1;
      end else begin
        cnt_r <= total;
        j_r   <= j_r + JW'(1);
      end
    end
  end

  // result select
  logic [PIX_W-1:0] res;
  logic [PIX_W:0]   mid_sum;

  always_comb begin
    mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
    unique case (filter_mode_r)
      MODE_MEDIAN:   res = p_r;
      MODE_MINIMUM:  res = lo_r;
      MODE_MAXIMUM:  res = hi_r;
      MODE_MIDPOINT: res = mid_sum[PIX_W:1];
      default:       res = p_r;
    endcase
  end

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic             out_eor_r, out_eof_r;

  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel_r <= res;
      out_eor_r   <= eor_r;
      out_eof_r   <= eof_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_pixel  = out_pixel_r;
  assign out_eor    = out_eor_r;
  assign out_eof    = out_eof_r;

  a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> lo_r <= hi_r) else $error("min above max");
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && eof_r |-> eor_r) else $error("frame end without row end");
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> EW'(col_r) < w_eff) else $error("column past width");

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for the rank-order window filter: raster frames, scoreboard, random flow control.
`timescale 1ns / 1ps
module tb;
  import rowf_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_K      = 7;
  localparam int SETTLE     = 100;       // cycles of quiet before a register write
  localparam int CYCLE_CAP  = 1_000_000;
  localparam int ITEM_GOAL  = 1800;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [15:0] data;
    bit          border;
    logic [7:0]  pixel;
  } step_t;

  typedef struct {
    logic [7:0] pixel;
    logic       eor;
    logic       eof;
  } filt_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic out_tuser;

  rank_order_window_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and expected filter outputs
  step_t pending[$];
  filt_t expected_px[$];
  int    errors = 0;
  int    pixels_sent = 0;
  int    results_seen = 0;
  int    phases = 0;
  int    planned = 0;
  longint cycles = 0;

  // shadow of the filter: geometry, window and line history
  logic [10:0] m_width  = 11'd1024;
  logic [15:0] m_height = 16'd1024;
  logic [2:0]  m_ksize  = 3'd3;
  logic [1:0]  m_mode   = MODE_MEDIAN;
  logic [7:0]  m_pad    = 8'd0;
  logic [7:0]  hist[MAX_W][MAX_K];
  logic [7:0]  win[MAX_K][MAX_K];
  int          col_pos = 0;
  int          row_pos = 0;

  // queue appends
  function automatic void append_step(step_t s);
    pending.insert(pending.size(), s);
  endfunction

  function automatic void append_result(filt_t r);
    expected_px.insert(expected_px.size(), r);
  endfunction

  function automatic void write_reg(logic [2:0] a, logic [15:0] d);
    case (a)
      REG_FRAME_WIDTH:  m_width  = d[10:0];
      REG_FRAME_HEIGHT: m_height = d[15:0];
      REG_WINDOW_SIZE:  m_ksize  = d[2:0];
      REG_FILTER_MODE:  m_mode   = d[1:0];
      REG_PAD_VALUE:    m_pad    = d[7:0];
      default: ;
    endcase
  endfunction

  // rank selection over the newest K columns and K rows of the window
  function automatic logic [7:0] rank_pick(int k);
    int vals[MAX_K*MAX_K];
    int n, p, x, lo, hi;
    n = 0; lo = 255; hi = 0;
    for (int j = MAX_K - k; j < MAX_K; j++)
      for (int i = 0; i < k; i++) begin
        x = win[j][i];
        p = n;
        while (p > 0 && vals[p-1] > x) begin
          vals[p] = vals[p-1];
          p--;
        end
        vals[p] = x;
        n++;
        if (x < lo) lo = x;
        if (x > hi) hi = x;
      end
    case (m_mode)
      MODE_MEDIAN:  return 8'(vals[(k*k)/2]);
      MODE_MINIMUM: return lo[7:0];
      MODE_MAXIMUM: return hi[7:0];
      default:      return 8'((lo + hi) >> 1);
    endcase
  endfunction

  // advance the shadow by one accepted position, queue a result if a window completes
  function automatic void filter_position(bit border, logic [7:0] pix);
    int w, h, k, c;
    logic [7:0] v;
    bit last_col, last_row;
    filt_t r;
    w = (m_width == 0) ? 1 : ((m_width > MAX_W) ? MAX_W : m_width);
    h = (m_height == 0) ? 1 : m_height;
    k = (m_ksize == 0) ? 1 : m_ksize;
    c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
    v = border ? m_pad : pix;
    for (int j = 0; j < MAX_K - 1; j++)
      for (int i = 0; i < MAX_K; i++) win[j][i] = win[j+1][i];
    win[MAX_K-1][0] = v;
    for (int i = 1; i < MAX_K; i++) win[MAX_K-1][i] = hist[c][i-1];
    for (int i = MAX_K - 1; i > 0; i--) hist[c][i] = hist[c][i-1];
    hist[c][0] = v;
    last_col = (c + 1 >= w);
    last_row = (row_pos + 1 >= h);
    if (c + 1 >= k && row_pos + 1 >= k) begin
      r.pixel = rank_pick(k);
      r.eor = last_col;
      r.eof = last_col && last_row;
      append_result(r);
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  // stimulus building
  function automatic void add_cfg(logic [2:0] a, int d);
    step_t s;
    s = '{is_cfg: 1'b1, addr: a, data: 16'(d), border: 1'b0, pixel: 8'd0};
    append_step(s);
  endfunction

  function automatic void add_geometry(int w, int h, int k, logic [1:0] mode, int pad);
    add_cfg(REG_FRAME_WIDTH, w);
    add_cfg(REG_FRAME_HEIGHT, h);
    add_cfg(REG_WINDOW_SIZE, k);
    add_cfg(REG_FILTER_MODE, mode);
    add_cfg(REG_PAD_VALUE, pad);
    phases++;
  endfunction

  // one full frame; its outer band is marked as border steps, and some steps have the mark flipped
  function automatic void add_frame(int w, int h, int band, int noise_pct);
    step_t s;
    int r;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        s.is_cfg = 1'b0; s.addr = '0; s.data = '0;
        s.border = (y < band || y >= h - band || x < band || x >= w - band);
        if ($urandom_range(0, 99) < noise_pct) s.border = ~s.border;
        r = $urandom_range(0, 9);
        s.pixel = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
        append_step(s);
        planned++;
      end
  endfunction

  initial begin
    logic [1:0] modes[4];
    int w, h, k, band;
    modes = '{MODE_MEDIAN, MODE_MINIMUM, MODE_MAXIMUM, MODE_MIDPOINT};
    // directed: every mode, with the pad value alternating between the two extremes
    foreach (modes[i]) begin
      add_geometry(3, 3, 3, modes[i], (i % 2) ? 255 : 0);
      add_frame(3, 3, 1, 0);
    end
    add_geometry(3, 2, 0, MODE_MEDIAN, 128);     // window 0 acts as 1
    add_frame(3, 2, 0, 0);
    add_geometry(2, 3, 5, MODE_MAXIMUM, 0);      // frame smaller than window
    add_frame(2, 3, 0, 0);
    add_geometry(0, 0, 1, MODE_MIDPOINT, 255);   // width and height 0 act as 1
    add_frame(1, 1, 0, 0);
    add_geometry(8, 8, 7, MODE_MEDIAN, 255);     // largest window, padded
    add_frame(8, 8, 3, 0);
    add_geometry(6, 6, 4, MODE_MEDIAN, 0);       // even window, upper median
    add_frame(6, 6, 2, 0);
    // width above the maximum runs rows of the widest size
    add_geometry(2047, 1, 1, MODE_MAXIMUM, 255);
    add_frame(1024, 1, 0, 5);
    // tallest frame cut short by a height change (single pixel window reads no history)
    add_geometry(1, 65535, 1, MODE_MEDIAN, 7);
    add_frame(1, 20, 0, 10);
    add_cfg(REG_FRAME_HEIGHT, 0);
    add_frame(1, 1, 0, 0);
    // random geometry and content
    while (planned < ITEM_GOAL) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      k = $urandom_range(0, 7);
      band = $urandom_range(0, 3);
      add_geometry(w, h, k, modes[$urandom_range(0, 3)],
                   ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255)
                   : ($urandom_range(0, 1) ? 255 : 0));
      repeat ($urandom_range(1, 3))
        add_frame(w, h, band, ($urandom_range(0, 3) == 0) ? 15 : 0);
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver: pixel transfers and idle-time register writes
  int  gap = 0;
  int  quiet = 0;
  bit  steady = 1'b0;
  step_t cur;
  always @(posedge clk) begin
    logic v, we;
    v = in_tvalid;
    we = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        filter_position(cur.border, cur.pixel);
        pixels_sent++;
        v = 1'b0;
      end
      quiet = (expected_px.size() == 0 && !v) ? quiet + 1 : 0;
      if (!v && pending.size() > 0) begin
        if (gap > 0) begin
          gap--;
        end else if (pending[0].is_cfg) begin
          if (quiet >= SETTLE) begin
            cur = pending.pop_front();
            write_reg(cur.addr, cur.data);
            cfg_addr <= cur.addr;
            cfg_wdata <= cur.data;
            we = 1'b1;
          end
        end else begin
          cur = pending.pop_front();
          in_tdata <= cur.pixel;
          in_tuser <= cur.border;
          v = 1'b1;
          if (pixels_sent % 64 == 0) steady = $urandom_range(0, 2) == 0;
          gap = steady ? 0 : $urandom_range(0, 4);
        end
      end
    end
    in_tvalid <= v;
    cfg_we <= we;
  end

  // monitor: result transfers against the oldest expectation
  int stall = 0;
  always @(posedge clk) begin
    filt_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_px.size() == 0) begin
          $error("result with nothing expected: pixel %0d", out_tdata);
          errors++;
        end else begin
          e = expected_px.pop_front();
          if (out_tdata !== e.pixel) begin
            $error("out_pixel: expected %0d, got %0d", e.pixel, out_tdata);
            errors++;
          end
          if (out_tlast !== e.eor) begin
            $error("end_of_row: expected %0b, got %0b", e.eor, out_tlast);
            errors++;
          end
          if (out_tuser !== e.eof) begin
            $error("end_of_frame: expected %0b, got %0b", e.eof, out_tuser);
            errors++;
          end
        end
        stall = steady ? 0 : $urandom_range(0, 4);
      end else if (stall > 0) begin
        stall--;
      end
      out_tready <= (stall == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (rst_n);
    wait (pending.size() == 0 && !in_tvalid && expected_px.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (expected_px.size() != 0) begin
      $error("%0d expected results never arrived", expected_px.size());
      errors++;
    end
    $display("covered %0d pixel transfers over %0d configurations, %0d filtered results",
             pixels_sent, phases, results_seen);
    $display("all four modes, pad extremes, window 0..7, width 0..2047, height 0..65535");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
